>>> design/rmfmm_pkg.sv
// ============================================================================
// rmfmm_pkg: shared types and constants of the recursive median filter
// Holds field widths, register indexes, reset values, the sequencer state
// type and the control bundle that drives the sample store.
// ============================================================================
package rmfmm_pkg;

    // Field widths
    localparam int DATA_W     = 16;
    localparam int WW_W       = 4;
    localparam int BL_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BL_W;
    localparam int BIT_CNT_W  = $clog2(DATA_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd1;

    // Reset values
    localparam logic [WW_W-1:0]   WW_RESET  = 4'd10;
    localparam logic [BL_W-1:0]   BL_RESET  = 13'd4096;
    localparam logic [DATA_W-1:0] MIN_RESET = 16'hFFFF;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_LOAD,
        ST_RUN,
        ST_EMIT
    } rmfmm_state_t;

    // Store control: write one raw sample, or advance both lines by one
    typedef struct packed {
        logic raw_write;
        logic advance;
    } rmfmm_store_ctl_t;

endpackage

>>> design/rmfmm_store.sv
// ============================================================================
// rmfmm_store: raw look-ahead line and filtered history line
// Raw samples land at a chosen slot; each produced result shifts the raw
// line down by one and pushes the filtered value onto the history line.
// ============================================================================
module rmfmm_store
    import rmfmm_pkg::*;
#(
    parameter int MAX_HALF = 5
)(
    input  logic                          clk,
    input  rmfmm_store_ctl_t              ctl,
    input  logic [$clog2(MAX_HALF+1)-1:0] raw_idx,
    input  logic [DATA_W-1:0]             raw_data,
    input  logic [DATA_W-1:0]             push_data,
    output logic [DATA_W-1:0]             raw_q  [MAX_HALF+1],
    output logic [DATA_W-1:0]             hist_q [MAX_HALF]
);

    logic [DATA_W-1:0] raw_reg  [MAX_HALF+1];
    logic [DATA_W-1:0] raw_next [MAX_HALF+1];
    logic [DATA_W-1:0] hist_reg  [MAX_HALF];
    logic [DATA_W-1:0] hist_next [MAX_HALF];

    always_comb
    begin
        raw_next  = raw_reg;
        hist_next = hist_reg;
        if (ctl.raw_write)
        begin
            raw_next[raw_idx] = raw_data;
        end
        if (ctl.advance)
        begin
            for (int k = 0; k < MAX_HALF; k++)
            begin
                raw_next[k] = raw_reg[k+1];
            end
            hist_next[0] = push_data;
            for (int k = 1; k < MAX_HALF; k++)
            begin
                hist_next[k] = hist_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        hist_reg <= hist_next;
    end

    assign raw_q  = raw_reg;
    assign hist_q = hist_reg;

endmodule

>>> design/rmfmm_select.sv
// ============================================================================
// rmfmm_select: bit-serial rank selector
// Finds the element of a given rank among the active slots, one bit per
// cycle from the MSB, by counting active slots whose current bit is zero.
// ============================================================================
module rmfmm_select
    import rmfmm_pkg::*;
#(
    parameter int SPAN = 11
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DATA_W-1:0]           slot_val [SPAN],
    input  logic [SPAN-1:0]             slot_act,
    input  logic [$clog2(SPAN+1)-1:0]   rank,
    output logic                        done,
    output logic [DATA_W-1:0]           result
);

    localparam int CNT_W = $clog2(SPAN+1);

    logic [DATA_W-1:0]    shift_reg  [SPAN];
    logic [DATA_W-1:0]    shift_next [SPAN];
    logic [SPAN-1:0]      act_reg, act_next;
    logic [CNT_W-1:0]     rank_reg, rank_next;
    logic [DATA_W-1:0]    res_reg, res_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPAN-1:0]      msb;
    logic [SPAN-1:0]      zeros;
    logic [CNT_W-1:0]     zero_cnt;
    logic                 pick_one;

    always_comb
    begin
        for (int j = 0; j < SPAN; j++)
        begin
            msb[j] = shift_reg[j][DATA_W-1];
        end
        zeros    = act_reg & ~msb;
        zero_cnt = '0;
        for (int j = 0; j < SPAN; j++)
        begin
            zero_cnt = zero_cnt + CNT_W'(zeros[j]);
        end
        // rank at or above the zero count: the answer bit is one
        pick_one = (rank_reg >= zero_cnt);

        shift_next = shift_reg;
        act_next   = act_reg;
        rank_next  = rank_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start)
        begin
            shift_next = slot_val;
            act_next   = slot_act;
            rank_next  = rank;
            bit_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < SPAN; j++)
            begin
                shift_next[j] = {shift_reg[j][DATA_W-2:0], 1'b0};
            end
            res_next = {res_reg[DATA_W-2:0], pick_one};
            if (pick_one)
            begin
                act_next  = act_reg & msb;
                rank_next = rank_reg - zero_cnt;
            end
            else
            begin
                act_next = zeros;
            end
            bit_next = bit_reg + BIT_CNT_W'(1);
            if (bit_reg == BIT_CNT_W'(DATA_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        act_reg   <= act_next;
        rank_reg  <= rank_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> design/recursive_median_filter_minmax_unit.sv
// ============================================================================
// recursive_median_filter_minmax_unit: recursive median filter with min/max
// Clipped, odd-width median over a block of 16-bit samples, in place, so
// that earlier window positions hold filtered values. Reports the block's
// filtered minimum and maximum on its final result when the window fits the block.
// ============================================================================
// A sample that completes a window goes through LOAD, RUN and EMIT, the
//   bit-serial selector working in RUN, before its result is registered;
//   a pass-through sample goes through PASS alone. No new sample is taken
//   until the one in hand is done; the final sample of a block repeats LOAD,
//   RUN and EMIT per pending position; a sample with no window stays IDLE.
// Reset: window width 10, block length 4096, position 0, no result pending.
// ============================================================================
module recursive_median_filter_minmax_unit
    import rmfmm_pkg::*;
#(
    parameter int MAX_HALF  = 5,
    parameter int BLOCK_MAX = 4096
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_W-1:0]     sample,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     filtered,
    output logic                  block_end,
    output logic [DATA_W-1:0]     min_seen,
    output logic [DATA_W-1:0]     max_seen,
    output logic                  bad_window
);

    // Window span, half-width, window count and position widths
    localparam int SPAN  = 2 * MAX_HALF + 1;
    localparam int H_W   = $clog2(MAX_HALF + 1);
    localparam int N_W   = $clog2(SPAN + 1);
    localparam int P_W   = $clog2(BLOCK_MAX);
    localparam int LEN_W = ($clog2(BLOCK_MAX + 1) > BL_W) ? $clog2(BLOCK_MAX + 1) : BL_W;
    localparam int C_W   = ((P_W > H_W) ? P_W : H_W) + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rmfmm_state_t      state_reg, state_next;
    logic [WW_W-1:0]   ww_reg, ww_next;
    logic [BL_W-1:0]   bl_reg, bl_next;
    logic [P_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0] run_min_reg, run_min_next;
    logic [DATA_W-1:0] run_max_reg, run_max_next;

    // per-sample working state
    logic [P_W-1:0]    item_p_reg, item_p_next;
    logic [P_W-1:0]    item_i_reg, item_i_next;
    logic              item_last_reg, item_last_next;
    logic [DATA_W-1:0] hold_reg, hold_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] filtered_reg, filtered_next;
    logic              block_end_reg, block_end_next;
    logic [DATA_W-1:0] min_seen_reg, min_seen_next;
    logic [DATA_W-1:0] max_seen_reg, max_seen_next;
    logic              bad_window_reg, bad_window_next;

    // ------------------------------------------------------------------
    // Block geometry from the configuration
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  blen_ext;
    logic [LEN_W-1:0]  eff_len;
    logic [WW_W-1:0]   half_raw;
    logic [H_W-1:0]    half;
    logic              is_bad;
    logic              is_last;
    logic [C_W-1:0]    pos_c, half_c, i0_c;
    logic [H_W-1:0]    raw_idx;
    logic              has_out;

    always_comb
    begin
        blen_ext = LEN_W'(bl_reg);
        // a zero length acts as one; clamp to the largest supported block
        if (bl_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (blen_ext > LEN_W'(BLOCK_MAX))
        begin
            eff_len = LEN_W'(BLOCK_MAX);
        end
        else
        begin
            eff_len = blen_ext;
        end

        // rounding up to odd then halving drops the low bit
        half_raw = ww_reg >> 1;
        half = ({1'b0, half_raw} > 5'(MAX_HALF)) ? H_W'(MAX_HALF) : H_W'(half_raw);

        is_bad  = (LEN_W'(ww_reg) > eff_len);
        is_last = ((LEN_W'(pos_reg) + LEN_W'(1)) >= eff_len);

        pos_c   = C_W'(pos_reg);
        half_c  = C_W'(half);
        // first position whose window this sample completes
        i0_c    = (pos_c >= half_c) ? (pos_c - half_c) : '0;
        raw_idx = H_W'(pos_c - i0_c);
        has_out = is_last || (pos_c >= half_c);
    end

    // ------------------------------------------------------------------
    // Window set-up for the current output position
    // ------------------------------------------------------------------
    logic [C_W-1:0]    ip_c, dist_c;
    logic [H_W-1:0]    hist_cnt;
    logic [H_W-1:0]    raw_last;
    logic [N_W-1:0]    win_cnt;
    logic [N_W-1:0]    sel_rank;
    logic [SPAN-1:0]   slot_act;
    logic [DATA_W-1:0] slot_val [SPAN];
    logic [DATA_W-1:0] raw_q    [MAX_HALF+1];
    logic [DATA_W-1:0] hist_q   [MAX_HALF];

    always_comb
    begin
        ip_c   = C_W'(item_i_reg);
        dist_c = C_W'(item_p_reg) - ip_c;
        // clip the window at the block start and at the newest sample
        hist_cnt = (ip_c < half_c) ? H_W'(ip_c) : half;
        raw_last = (dist_c < half_c) ? H_W'(dist_c) : half;
        win_cnt  = N_W'(hist_cnt) + N_W'(raw_last) + N_W'(1);
        // upper middle on an even count
        sel_rank = win_cnt >> 1;

        for (int j = 0; j < MAX_HALF; j++)
        begin
            slot_val[j] = hist_q[j];
            slot_act[j] = (H_W'(j) < hist_cnt);
        end
        for (int k = 0; k <= MAX_HALF; k++)
        begin
            slot_val[MAX_HALF+k] = raw_q[k];
            slot_act[MAX_HALF+k] = (H_W'(k) <= raw_last);
        end
    end

    // ------------------------------------------------------------------
    // Sample store and selector
    // ------------------------------------------------------------------
    rmfmm_store_ctl_t  store_ctl;
    logic              sel_start;
    logic              sel_done;
    logic [DATA_W-1:0] sel_result;

    rmfmm_store #(
        .MAX_HALF (MAX_HALF)
    ) u_store (
        .clk       (clk),
        .ctl       (store_ctl),
        .raw_idx   (raw_idx),
        .raw_data  (sample),
        .push_data (sel_result),
        .raw_q     (raw_q),
        .hist_q    (hist_q)
    );

    rmfmm_select #(
        .SPAN (SPAN)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sel_start),
        .slot_val (slot_val),
        .slot_act (slot_act),
        .rank     (sel_rank),
        .done     (sel_done),
        .result   (sel_result)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic              out_free;
    logic              final_out;
    logic [DATA_W-1:0] new_min, new_max;

    assign out_free  = !out_valid_reg || out_ready;
    assign final_out = item_last_reg && (item_i_reg == item_p_reg);
    assign new_min   = (sel_result < run_min_reg) ? sel_result : run_min_reg;
    assign new_max   = (sel_result > run_max_reg) ? sel_result : run_max_reg;

    always_comb
    begin
        state_next      = state_reg;
        ww_next         = ww_reg;
        bl_next         = bl_reg;
        pos_next        = pos_reg;
        run_min_next    = run_min_reg;
        run_max_next    = run_max_reg;
        item_p_next     = item_p_reg;
        item_i_next     = item_i_reg;
        item_last_next  = item_last_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        filtered_next   = filtered_reg;
        block_end_next  = block_end_reg;
        min_seen_next   = min_seen_reg;
        max_seen_next   = max_seen_reg;
        bad_window_next = bad_window_reg;
        store_ctl       = '0;
        sel_start       = 1'b0;
        in_ready        = 1'b0;

        // drop the held result once its transaction completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    hold_next      = sample;
                    item_last_next = is_last;
                    item_p_next    = pos_reg;
                    item_i_next    = P_W'(i0_c);
                    pos_next       = is_last ? '0 : (pos_reg + P_W'(1));
                    if (is_bad)
                    begin
                        state_next = ST_PASS;
                    end
                    else
                    begin
                        // store the sample; it may complete no window yet
                        store_ctl.raw_write = 1'b1;
                        if (has_out)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_PASS:
            begin
                // window wider than the block: pass the sample unchanged
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    filtered_next   = hold_reg;
                    block_end_next  = item_last_reg;
                    min_seen_next   = '0;
                    max_seen_next   = '0;
                    bad_window_next = 1'b1;
                    if (item_last_reg)
                    begin
                        run_min_next = MIN_RESET;
                        run_max_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_LOAD:
            begin
                sel_start  = 1'b1;
                state_next = ST_RUN;
            end

            ST_RUN:
            begin
                if (sel_done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    filtered_next   = sel_result;
                    block_end_next  = final_out;
                    min_seen_next   = final_out ? new_min : '0;
                    max_seen_next   = final_out ? new_max : '0;
                    bad_window_next = 1'b0;
                    // push the filtered value into history, advance the raw line
                    store_ctl.advance = 1'b1;
                    if (final_out)
                    begin
                        run_min_next = MIN_RESET;
                        run_max_next = '0;
                    end
                    else
                    begin
                        run_min_next = new_min;
                        run_max_next = new_max;
                    end
                    // the block's final sample flushes every pending position
                    if (item_last_reg && !final_out)
                    begin
                        item_i_next = item_i_reg + P_W'(1);
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // any configuration write abandons the block in progress
        if (cfg_write)
        begin
            pos_next     = '0;
            run_min_next = MIN_RESET;
            run_max_next = '0;
            case (cfg_index)
                CFG_WINDOW_WIDTH: ww_next = cfg_data[WW_W-1:0];
                CFG_BLOCK_LENGTH: bl_next = cfg_data[BL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ww_reg        <= WW_RESET;
            bl_reg        <= BL_RESET;
            pos_reg       <= '0;
            run_min_reg   <= MIN_RESET;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ww_reg        <= ww_next;
            bl_reg        <= bl_next;
            pos_reg       <= pos_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_p_reg     <= item_p_next;
        item_i_reg     <= item_i_next;
        item_last_reg  <= item_last_next;
        hold_reg       <= hold_next;
        filtered_reg   <= filtered_next;
        block_end_reg  <= block_end_next;
        min_seen_reg   <= min_seen_next;
        max_seen_reg   <= max_seen_next;
        bad_window_reg <= bad_window_next;
    end

    assign out_valid  = out_valid_reg;
    assign filtered   = filtered_reg;
    assign block_end  = block_end_reg;
    assign min_seen   = min_seen_reg;
    assign max_seen   = max_seen_reg;
    assign bad_window = bad_window_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cfg_restarts_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (pos_reg == '0 && run_max_reg == '0 && run_min_reg == MIN_RESET))
        else $error("configuration write did not restart the block");

    a_pass_no_extrema: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_window_reg) |-> (min_seen_reg == '0 && max_seen_reg == '0))
        else $error("pass-through result carries extrema");

    a_mid_block_no_extrema: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !block_end_reg) |-> (min_seen_reg == '0 && max_seen_reg == '0))
        else $error("extrema reported before the end of the block");

    a_extrema_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && block_end_reg && !bad_window_reg) |-> (min_seen_reg <= max_seen_reg))
        else $error("block minimum above block maximum");

    a_select_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        sel_done |-> (state_reg == ST_RUN))
        else $error("selector finished outside the run state");

endmodule
